### hdl/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

	localparam int DEF_MAX_COLUMNS = 80;
	localparam int DEF_MAX_ROWS    = 25;

	localparam int COL_W      = 7;
	localparam int ROW_W      = 5;
	localparam int POS_W      = COL_W + ROW_W;
	localparam int IDX_W      = 11;
	localparam int CELL_W     = 16;
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 4;
	localparam int ACT_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FG      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BG      = 2'd3;

	localparam logic [COL_W-1:0]   RST_COLUMNS = 7'd80;
	localparam logic [ROW_W-1:0]   RST_ROWS    = 5'd25;
	localparam logic [COLOR_W-1:0] RST_FG      = 4'd7;
	localparam logic [COLOR_W-1:0] RST_BG      = 4'd0;

	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [CHAR_W-1:0] character;
		logic [IDX_W-1:0]  read_index;
	} tcw_req_t;

	typedef struct packed {
		logic              cell_written;
		logic [IDX_W-1:0]  cell_index;
		logic [CELL_W-1:0] cell_value;
		logic              cursor_update;
		logic [IDX_W-1:0]  cursor_position;
		logic              scrolled;
		logic [CELL_W-1:0] read_data;
	} tcw_rsp_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_COPY,
		ST_DRAIN,
		ST_BLANK,
		ST_WRITE,
		ST_FINISH,
		ST_CLEAR,
		ST_CLEAR_DONE
	} tcw_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_FILL_RESET,
		OP_ACCEPT,
		OP_NEWLINE,
		OP_CR,
		OP_PUT,
		OP_SCROLL_START,
		OP_COPY,
		OP_BLANK,
		OP_READ_ISSUE,
		OP_READ_DONE,
		OP_CLEAR_STEP,
		OP_CLEAR_DONE,
		OP_FINISH
	} tcw_op_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             is_lf;
		logic             is_cr;
		logic             wrap;
		logic             last_row;
		logic             copy_none;
		logic             copy_last;
		logic             blank_last;
		logic             fill_last;
		logic             out_free;
	} tcw_status_t;

endpackage

### hdl/tcw_ctrl.sv
// Sequencing state machine of the text console writer.
module tcw_ctrl import tcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  tcw_status_t status,
	output tcw_op_t     op
);

	tcw_state_t state_q;
	tcw_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		op        = OP_NONE;
		req_stall = 1'b1;
		case (state_q)
			ST_INIT: begin
				op = OP_FILL_RESET;
				if (status.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					op      = OP_ACCEPT;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (status.action)
					ACT_PUT: begin
						if (status.is_lf) begin
							if (status.last_row) begin
								op      = OP_SCROLL_START;
								state_d = status.copy_none ? ST_BLANK : ST_COPY;
							end else if (status.out_free) begin
								op      = OP_NEWLINE;
								state_d = ST_IDLE;
							end
						end else if (status.is_cr) begin
							if (status.out_free) begin
								op      = OP_CR;
								state_d = ST_IDLE;
							end
						end else if (status.wrap && status.last_row) begin
							op      = OP_SCROLL_START;
							state_d = status.copy_none ? ST_BLANK : ST_COPY;
						end else if (status.out_free) begin
							op      = OP_PUT;
							state_d = ST_IDLE;
						end
					end
					ACT_READ: begin
						op      = OP_READ_ISSUE;
						state_d = ST_READ;
					end
					ACT_CLEAR: begin
						op      = OP_CLEAR_STEP;
						state_d = status.fill_last ? ST_CLEAR_DONE : ST_CLEAR;
					end
					default: begin
						if (status.out_free) begin
							op      = OP_FINISH;
							state_d = ST_IDLE;
						end
					end
				endcase
			end
			ST_READ: begin
				if (status.out_free) begin
					op      = OP_READ_DONE;
					state_d = ST_IDLE;
				end
			end
			ST_COPY: begin
				op = OP_COPY;
				if (status.copy_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_BLANK;
			end
			ST_BLANK: begin
				op = OP_BLANK;
				if (status.blank_last) begin
					state_d = status.is_lf ? ST_FINISH : ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (status.out_free) begin
					op      = OP_PUT;
					state_d = ST_IDLE;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					op      = OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				op = OP_CLEAR_STEP;
				if (status.fill_last) begin
					state_d = ST_CLEAR_DONE;
				end
			end
			ST_CLEAR_DONE: begin
				if (status.out_free) begin
					op      = OP_CLEAR_DONE;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule

### hdl/tcw_datapath.sv
// Screen store, cursor, configuration registers and result register.
module tcw_datapath import tcw_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcw_op_t               op,
	output tcw_status_t           status,
	input  tcw_req_t              req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output tcw_rsp_t              rsp_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;
	localparam int AW = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;

	logic [COL_W-1:0]   cfg_cols_q;
	logic [ROW_W-1:0]   cfg_rows_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;

	logic [COL_W-1:0]   cols_eff;
	logic [ROW_W-1:0]   rows_eff;
	logic [CHAR_W-1:0]  color;
	logic [CELL_W-1:0]  blank;

	tcw_req_t           req_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               scr_q;
	logic [COL_W-1:0]   col_sat;
	logic [ROW_W-1:0]   row_sat;
	logic [ROW_W-1:0]   row_inc;
	logic               wrap;
	logic               last_row;

	logic [ROW_W-1:0]   mul_row;
	logic [POS_W-1:0]   prod;
	logic [COL_W-1:0]   put_col;
	logic [COL_W-1:0]   base_col;
	logic [POS_W-1:0]   pos_sum;
	logic [POS_W-1:0]   pos_after;

	logic [POS_W-1:0]   rd_ptr_q;
	logic [POS_W-1:0]   wr_ptr_q;
	logic [POS_W-1:0]   total_q;
	logic               cp_v_s1;
	logic [AW-1:0]      fill_cnt_q;

	logic [CELL_W-1:0]  cells_q [STORE_CELLS];
	logic [CELL_W-1:0]  rd_data_q;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [CELL_W-1:0]  wdata;
	logic               ren;
	logic [AW-1:0]      raddr;
	logic               rd_ok;

	logic               load;
	tcw_rsp_t           rsp_d;
	tcw_rsp_t           rsp_q;
	logic               rsp_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cols_q <= RST_COLUMNS;
			cfg_rows_q <= RST_ROWS;
			fg_q       <= RST_FG;
			bg_q       <= RST_BG;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COLUMNS: cfg_cols_q <= cfg_data;
				CFG_ROWS:    cfg_rows_q <= cfg_data[ROW_W-1:0];
				CFG_FG:      fg_q       <= cfg_data[COLOR_W-1:0];
				CFG_BG:      bg_q       <= cfg_data[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (cfg_cols_q == '0) begin
			cols_eff = COL_W'(1);
		end else if (int'(cfg_cols_q) > MAX_COLUMNS) begin
			cols_eff = COL_W'(MAX_COLUMNS);
		end else begin
			cols_eff = cfg_cols_q;
		end
		if (cfg_rows_q == '0) begin
			rows_eff = ROW_W'(1);
		end else if (int'(cfg_rows_q) > MAX_ROWS) begin
			rows_eff = ROW_W'(MAX_ROWS);
		end else begin
			rows_eff = cfg_rows_q;
		end
	end

	assign color = {bg_q, fg_q};
	assign blank = {color, CH_SPACE};

	assign col_sat  = (col_q > cols_eff) ? cols_eff : col_q;
	assign row_sat  = (row_q >= rows_eff) ? rows_eff - ROW_W'(1) : row_q;
	assign row_inc  = row_q + ROW_W'(1);
	assign wrap     = (col_q >= cols_eff);
	assign last_row = ((ROW_W+1)'(row_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(rows_eff);

	assign mul_row  = ((op == OP_NEWLINE) || ((op == OP_PUT) && wrap)) ? row_inc : row_q;
	assign prod     = POS_W'(mul_row) * POS_W'(cols_eff);
	assign put_col  = wrap ? '0 : col_q;

	always_comb begin
		case (op)
			OP_PUT:     base_col = put_col;
			OP_NEWLINE: base_col = '0;
			OP_CR:      base_col = '0;
			default:    base_col = col_q;
		endcase
	end

	assign pos_sum = POS_W'(base_col) + prod;

	always_comb begin
		case (op)
			OP_PUT:        pos_after = pos_sum + POS_W'(1);
			OP_CLEAR_DONE: pos_after = '0;
			default:       pos_after = pos_sum;
		endcase
	end

	always_ff @(posedge clk) begin
		if (op == OP_ACCEPT) begin
			req_q <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			scr_q <= 1'b0;
		end else begin
			case (op)
				OP_ACCEPT: begin
					col_q <= col_sat;
					row_q <= row_sat;
					scr_q <= 1'b0;
				end
				OP_NEWLINE: begin
					col_q <= '0;
					row_q <= row_inc;
				end
				OP_CR: begin
					col_q <= '0;
				end
				OP_PUT: begin
					col_q <= put_col + COL_W'(1);
					row_q <= wrap ? row_inc : row_q;
				end
				OP_SCROLL_START: begin
					col_q <= '0;
					scr_q <= 1'b1;
				end
				OP_CLEAR_DONE: begin
					col_q <= '0;
					row_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// scroll: read one row ahead, write the data in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			total_q  <= '0;
			cp_v_s1  <= 1'b0;
		end else begin
			cp_v_s1 <= (op == OP_COPY);
			if (op == OP_SCROLL_START) begin
				rd_ptr_q <= POS_W'(cols_eff);
				wr_ptr_q <= '0;
				total_q  <= POS_W'(rows_eff) * POS_W'(cols_eff);
			end else begin
				if (op == OP_COPY) begin
					rd_ptr_q <= rd_ptr_q + POS_W'(1);
				end
				if (cp_v_s1 || (op == OP_BLANK)) begin
					wr_ptr_q <= wr_ptr_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
		end else if (op == OP_ACCEPT) begin
			fill_cnt_q <= '0;
		end else if ((op == OP_FILL_RESET) || (op == OP_CLEAR_STEP)) begin
			fill_cnt_q <= fill_cnt_q + AW'(1);
		end
	end

	assign rd_ok = int'(req_q.read_index) < STORE_CELLS;

	always_comb begin
		we    = 1'b0;
		waddr = AW'(wr_ptr_q);
		wdata = blank;
		if (cp_v_s1) begin
			we    = 1'b1;
			wdata = rd_data_q;
		end else begin
			case (op)
				OP_FILL_RESET: begin
					we    = 1'b1;
					waddr = fill_cnt_q;
					wdata = RESET_CELL;
				end
				OP_CLEAR_STEP: begin
					we    = 1'b1;
					waddr = fill_cnt_q;
				end
				OP_BLANK: begin
					we = 1'b1;
				end
				OP_PUT: begin
					we    = 1'b1;
					waddr = AW'(pos_sum);
					wdata = {color, req_q.character};
				end
				default: begin
				end
			endcase
		end
	end

	assign ren   = (op == OP_COPY) || ((op == OP_READ_ISSUE) && rd_ok);
	assign raddr = (op == OP_COPY) ? AW'(rd_ptr_q) : AW'(req_q.read_index);

	always_ff @(posedge clk) begin
		if (we) begin
			cells_q[waddr] <= wdata;
		end
		if (ren) begin
			rd_data_q <= cells_q[raddr];
		end
	end

	always_comb begin
		rsp_d                 = '0;
		rsp_d.cursor_position = IDX_W'(pos_after);
		rsp_d.scrolled        = scr_q;
		load                  = 1'b0;
		case (op)
			OP_NEWLINE, OP_CR, OP_FINISH: begin
				load = 1'b1;
			end
			OP_PUT: begin
				load                = 1'b1;
				rsp_d.cell_written  = 1'b1;
				rsp_d.cell_index    = IDX_W'(pos_sum);
				rsp_d.cell_value    = {color, req_q.character};
				rsp_d.cursor_update = 1'b1;
			end
			OP_READ_DONE: begin
				load            = 1'b1;
				rsp_d.read_data = rd_ok ? rd_data_q : '0;
			end
			OP_CLEAR_DONE: begin
				load                = 1'b1;
				rsp_d.cursor_update = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign status.action     = req_q.action;
	assign status.is_lf      = (req_q.character == CH_LF);
	assign status.is_cr      = (req_q.character == CH_CR);
	assign status.wrap       = wrap;
	assign status.last_row   = last_row;
	assign status.copy_none  = (rows_eff == ROW_W'(1));
	assign status.copy_last  = (rd_ptr_q == total_q - POS_W'(1));
	assign status.blank_last = (wr_ptr_q == total_q - POS_W'(1));
	assign status.fill_last  = (fill_cnt_q == AW'(STORE_CELLS - 1));
	assign status.out_free   = !rsp_valid_q || !rsp_stall;

endmodule

### hdl/text_console_writer_unit.sv
// Text console writer: screen store of character cells with cursor, scroll and clear.
// One request at a time. A printable byte, a carriage return or a newline that
// does not scroll is accepted, then executed once the output register is free (a
// printable byte makes a single write on the store's port); a cell read goes through a
// registered store read. A scroll moves one cell per cycle through the store's single
// write port; a clear writes MAX_COLUMNS*MAX_ROWS cells, one per cycle. After reset a
// fill pass writes MAX_COLUMNS*MAX_ROWS cells, loading every cell with a space in color
// 0x07 while requests stall; configuration writes are taken throughout. A finished
// result waits in an output register, and the next request is accepted while it waits.
module text_console_writer_unit import tcw_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  tcw_req_t              req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output tcw_rsp_t              rsp_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	tcw_op_t     op;
	tcw_status_t status;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.op        (op)
	);

	tcw_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.status    (status),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

### hdl/tcw_checker.sv
// Port-level assertions for the text console writer, bound to the top level.
module tcw_checker import tcw_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input tcw_rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed or dropped");

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request accepted while one is at work");

	a_put_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.cell_written |->
			rsp_data.cursor_update &&
			(rsp_data.cursor_position == IDX_W'(rsp_data.cell_index + IDX_W'(1))))
		else $error("cursor does not follow the written cell");

	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.read_data != '0) |->
			!rsp_data.cell_written && !rsp_data.cursor_update && !rsp_data.scrolled)
		else $error("read data mixed with a write result");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);

### dv/tb_text_console_writer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text console writer: cursor, wrap, scroll, clear and cell reads.
module tb_text_console_writer_unit;
	import tcw_pkg::*;

	localparam int STORE_CELLS = DEF_MAX_COLUMNS * DEF_MAX_ROWS;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 94;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	tcw_req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	tcw_rsp_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	text_console_writer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// console state as the block should hold it
	logic [CELL_W-1:0] screen [STORE_CELLS];
	int cur_col;
	int cur_row;
	logic [COL_W-1:0] set_columns;
	logic [ROW_W-1:0] set_rows;
	logic [COLOR_W-1:0] set_fg;
	logic [COLOR_W-1:0] set_bg;

	tcw_rsp_t outstanding_reports[$];
	tcw_rsp_t want_report;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int failures = 0;
	int requests_sent = 0;
	int reports_checked = 0;
	int scrolls_seen = 0;
	int clears_sent = 0;
	int settings_applied = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int span_columns();
		if (set_columns < 1) return 1;
		if (set_columns > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
		return int'(set_columns);
	endfunction

	function automatic int span_rows();
		if (set_rows < 1) return 1;
		if (set_rows > DEF_MAX_ROWS) return DEF_MAX_ROWS;
		return int'(set_rows);
	endfunction

	function automatic logic [CELL_W-1:0] blank_cell();
		return {set_bg, set_fg, CH_SPACE};
	endfunction

	function automatic logic line_feed(int cols, int nrows);
		int moved;
		cur_col = 0;
		if (cur_row + 1 >= nrows) begin
			moved = (nrows - 1) * cols;
			for (int i = 0; i < moved; i++)
				screen[i] = screen[i + cols];
			for (int i = 0; i < cols; i++)
				screen[moved + i] = blank_cell();
			return 1'b1;
		end
		cur_row++;
		return 1'b0;
	endfunction

	function automatic tcw_rsp_t console_apply(tcw_req_t r);
		int cols;
		int nrows;
		int idx;
		int pos;
		logic [CELL_W-1:0] val;
		tcw_rsp_t o;
		cols = span_columns();
		nrows = span_rows();
		o = '0;
		if (cur_row >= nrows) cur_row = nrows - 1;
		if (cur_col > cols) cur_col = cols;
		case (r.action)
			ACT_PUT: begin
				if (r.character == CH_LF) begin
					o.scrolled = line_feed(cols, nrows);
				end else if (r.character == CH_CR) begin
					cur_col = 0;
				end else begin
					if (cur_col >= cols) o.scrolled = line_feed(cols, nrows);
					idx = cur_col + cur_row * cols;
					val = {set_bg, set_fg, r.character};
					if (idx < STORE_CELLS) screen[idx] = val;
					o.cell_written = 1'b1;
					o.cell_index = idx[IDX_W-1:0];
					o.cell_value = val;
					cur_col++;
					o.cursor_update = 1'b1;
				end
			end
			ACT_READ: begin
				if (r.read_index < STORE_CELLS) o.read_data = screen[r.read_index];
			end
			ACT_CLEAR: begin
				for (int i = 0; i < STORE_CELLS; i++)
					screen[i] = blank_cell();
				cur_col = 0;
				cur_row = 0;
				o.cursor_update = 1'b1;
			end
			default: ;
		endcase
		pos = cur_col + cur_row * cols;
		o.cursor_position = pos[IDX_W-1:0];
		return o;
	endfunction

	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < stall_pct);

	task automatic compare_field(string name, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (outstanding_reports.size() == 0) begin
				$error("report arrived with none outstanding");
				failures++;
			end else begin
				want_report = outstanding_reports.pop_front();
				compare_field("cell_written", want_report.cell_written, rsp_data.cell_written);
				compare_field("cell_index", want_report.cell_index, rsp_data.cell_index);
				compare_field("cell_value", want_report.cell_value, rsp_data.cell_value);
				compare_field("cursor_update", want_report.cursor_update,
					rsp_data.cursor_update);
				compare_field("cursor_position", want_report.cursor_position,
					rsp_data.cursor_position);
				compare_field("scrolled", want_report.scrolled, rsp_data.scrolled);
				compare_field("read_data", want_report.read_data, rsp_data.read_data);
				reports_checked++;
				if (want_report.scrolled) scrolls_seen++;
			end
		end
	end

	task automatic send_request(tcw_req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		outstanding_reports.push_back(console_apply(r));
		requests_sent++;
		if (r.action == ACT_CLEAR) clears_sent++;
	endtask

	task automatic send_op(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] ch,
			logic [IDX_W-1:0] ridx);
		tcw_req_t r;
		r.action = act;
		r.character = ch;
		r.read_index = ridx;
		send_request(r);
	endtask

	// hold off until every report is back and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_COLUMNS: set_columns = d[COL_W-1:0];
			CFG_ROWS: set_rows = d[ROW_W-1:0];
			CFG_FG: set_fg = d[COLOR_W-1:0];
			default: set_bg = d[COLOR_W-1:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_screen(int cols, int nrows, int fg, int bg);
		logic [CFG_DATA_W-1:0] d;
		settle();
		write_register(CFG_COLUMNS, cols[COL_W-1:0]);
		d = CFG_DATA_W'($urandom);
		d[ROW_W-1:0] = nrows[ROW_W-1:0];
		write_register(CFG_ROWS, d);
		d = CFG_DATA_W'($urandom);
		d[COLOR_W-1:0] = fg[COLOR_W-1:0];
		write_register(CFG_FG, d);
		d = CFG_DATA_W'($urandom);
		d[COLOR_W-1:0] = bg[COLOR_W-1:0];
		write_register(CFG_BG, d);
		settings_applied++;
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 71; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 71; end
			default: begin send_idle_pct = 10; stall_pct = 10; end
		endcase
	endtask

	function automatic tcw_req_t random_request();
		tcw_req_t r;
		int pick;
		pick = $urandom_range(999);
		r.action = ACT_PUT;
		r.character = CHAR_W'($urandom);
		r.read_index = IDX_W'($urandom);
		if (pick < 15) begin
			r.action = ACT_CLEAR;
		end else if (pick < 35) begin
			r.action = ACT_UNUSED;
		end else if (pick < 185) begin
			r.action = ACT_READ;
			if (pick < 150)
				r.read_index = IDX_W'($urandom_range(span_columns() * span_rows() - 1));
		end else if (pick < 255) begin
			r.character = CH_LF;
		end else if (pick < 285) begin
			r.character = CH_CR;
		end
		return r;
	endfunction

	task automatic test_power_on_screen();
		send_op(ACT_READ, 8'h00, 11'd0);
		send_op(ACT_READ, 8'hFF, 11'd1999);
		send_op(ACT_READ, 8'h00, 11'd2000);
		send_op(ACT_READ, 8'h00, 11'd2047);
	endtask

	task automatic test_single_bytes();
		send_op(ACT_PUT, 8'h00, 11'd2047);
		send_op(ACT_PUT, 8'hFF, 11'd0);
		send_op(ACT_PUT, "A", 11'd0);
		send_op(ACT_PUT, CH_CR, 11'd0);
		send_op(ACT_PUT, CH_LF, 11'd0);
		send_op(ACT_UNUSED, 8'hFF, 11'd2047);
	endtask

	// zero-sized registers saturate to a one-cell screen
	task automatic test_tiny_screen();
		program_screen(0, 0, 15, 15);
		send_op(ACT_PUT, "x", 11'd0);
		send_op(ACT_PUT, "y", 11'd0);
		send_op(ACT_PUT, CH_LF, 11'd0);
		send_op(ACT_READ, 8'h00, 11'd0);
	endtask

	task automatic test_shrunk_cursor();
		program_screen(127, 31, RST_FG, RST_BG);
		send_op(ACT_CLEAR, 8'h00, 11'd0);
		send_op(ACT_PUT, CH_LF, 11'd0);
		send_op(ACT_PUT, CH_LF, 11'd0);
		send_op(ACT_PUT, "q", 11'd0);
		program_screen(1, 2, 0, 15);
		send_op(ACT_PUT, "z", 11'd0);
		send_op(ACT_READ, 8'h00, 11'd0);
		send_op(ACT_READ, 8'h00, 11'd1);
	endtask

	task automatic test_random_traffic();
		int phase_cols [PHASES] = '{80, 1, 0, 127, 5, 12, 3, 80, 1, 40, 9, 2};
		int phase_rows [PHASES] = '{25, 1, 0, 31, 3, 4, 7, 1, 25, 10, 2, 6};
		int fg;
		int bg;
		for (int p = 0; p < PHASES; p++) begin
			fg = (p == 0) ? 0 : (p == 1) ? 15 : $urandom_range(15);
			bg = (p == 0) ? 15 : (p == 1) ? 0 : $urandom_range(15);
			program_screen(phase_cols[p], phase_rows[p], fg, bg);
			set_idling(p % 4);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(random_request());
		end
		set_idling(0);
	endtask

	initial begin
		set_columns = RST_COLUMNS;
		set_rows = RST_ROWS;
		set_fg = RST_FG;
		set_bg = RST_BG;
		cur_col = 0;
		cur_row = 0;
		for (int i = 0; i < STORE_CELLS; i++)
			screen[i] = RESET_CELL;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_power_on_screen();
		test_single_bytes();
		test_tiny_screen();
		test_shrunk_cursor();
		test_random_traffic();

		settle();
		if (outstanding_reports.size() != 0) begin
			$error("%0d reports never arrived", outstanding_reports.size());
			failures++;
		end
		$display("Sent %0d requests (%0d clears) under %0d screen settings,",
			requests_sent, clears_sent, settings_applied);
		$display("checked %0d reports, %0d of them with a scroll.",
			reports_checked, scrolls_seen);
		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
